### hw/rtl/dnsq_pkg.sv
// ----------------------------------------------------------------------------
// dnsq_pkg
// Shared types and constants for the DNS request question capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsq_pkg;

	// Parser phases, one per protocol header plus capture and a drop state
	typedef enum logic [2:0] {
		PH_ETH  = 3'd0,
		PH_IP   = 3'd1,
		PH_UDP  = 3'd2,
		PH_DNS  = 3'd3,
		PH_CAP  = 3'd4,
		PH_IDLE = 3'd5
	} phase_t;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
	localparam logic [3:0]  IHL_MIN        = 4'd5;
	// UDP header (8) plus DNS header (12)
	localparam logic [15:0] UDP_DNS_HDR    = 16'd20;
	localparam logic [15:0] DNS_PORT_RESET = 16'd53;

	// Header byte offsets
	localparam logic [5:0] ETH_TYPE_HI  = 6'd12;
	localparam logic [5:0] ETH_TYPE_LO  = 6'd13;
	localparam logic [5:0] IP_IDENT_HI  = 6'd4;
	localparam logic [5:0] IP_IDENT_LO  = 6'd5;
	localparam logic [5:0] IP_PROTO     = 6'd9;
	localparam logic [5:0] IP_SRC_FIRST = 6'd12;
	localparam logic [5:0] IP_SRC_LAST  = 6'd15;
	localparam logic [5:0] UDP_DPORT_HI = 6'd2;
	localparam logic [5:0] UDP_DPORT_LO = 6'd3;
	localparam logic [5:0] UDP_LEN_LO   = 6'd5;
	localparam logic [5:0] UDP_LAST     = 6'd7;
	localparam logic [5:0] DNS_FLAGS_HI = 6'd2;
	localparam logic [5:0] DNS_LAST     = 6'd11;

	// One result beat
	typedef struct packed {
		logic [31:0] source_address;
		logic [15:0] packet_ident;
		logic [7:0]  query_byte;
		logic [3:0]  byte_index;
		logic        has_byte;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/dnsq_parser.sv
// ----------------------------------------------------------------------------
// dnsq_parser
// Per-byte header walker: holds the parse state and, for each beat that
// advances, computes the next state and an optional result in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsq_parser #(
	parameter int CAPTURE_BYTES = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [7:0]       beat_byte,
	input  wire logic             beat_end,
	input  wire logic [15:0]      dns_port,
	output logic                  res_valid,
	output dnsq_pkg::result_t     res
);

	localparam int CW = ($clog2(CAPTURE_BYTES + 1) > 4) ? $clog2(CAPTURE_BYTES + 1) : 4;

	dnsq_pkg::phase_t phase_q, phase_n;
	logic [5:0]  pos_q, pos_n;
	logic [15:0] shift_q, shift_n;
	logic [5:0]  ihl_q, ihl_n;
	logic [31:0] src_q, src_n;
	logic [15:0] ident_q, ident_n;
	logic [15:0] rem_q, rem_n;
	logic [CW-1:0] cnt_q, cnt_n;

	logic [5:0]    pos_inc;
	logic [15:0]   shifted;
	logic [CW-1:0] cnt_inc;
	logic [15:0]   rem_dec;
	logic          cap_last;
	logic          dns_empty;

	assign pos_inc   = pos_q + 6'd1;
	assign shifted   = {shift_q[7:0], beat_byte};
	assign cnt_inc   = cnt_q + CW'(1);
	assign rem_dec   = rem_q - 16'd1;
	assign cap_last  = (cnt_inc >= CW'(CAPTURE_BYTES)) || (rem_dec == 16'd0) || beat_end;
	assign dns_empty = (rem_q == 16'd0) || beat_end;

	// Next state
	always_comb begin
		logic stay;
		logic drop;
		logic [15:0] sh;
		stay    = 1'b1;
		drop    = 1'b0;
		sh      = shift_q;
		phase_n = phase_q;
		pos_n   = pos_q;
		shift_n = shift_q;
		ihl_n   = ihl_q;
		src_n   = src_q;
		ident_n = ident_q;
		rem_n   = rem_q;
		cnt_n   = cnt_q;
		case (phase_q)
			dnsq_pkg::PH_ETH: begin
				if (pos_q >= dnsq_pkg::ETH_TYPE_HI) shift_n = shifted;
				if (pos_q == dnsq_pkg::ETH_TYPE_LO) begin
					stay    = 1'b0;
					pos_n   = '0;
					phase_n = (shifted == dnsq_pkg::ETHERTYPE_IPV4) ?
						dnsq_pkg::PH_IP : dnsq_pkg::PH_IDLE;
				end
			end
			dnsq_pkg::PH_IP: begin
				if (pos_q == '0) begin
					if (beat_byte[3:0] < dnsq_pkg::IHL_MIN) drop = 1'b1;
					else ihl_n = {beat_byte[3:0], 2'b00};
				end else if (pos_q == dnsq_pkg::IP_IDENT_HI || pos_q == dnsq_pkg::IP_IDENT_LO) begin
					ident_n = {ident_q[7:0], beat_byte};
				end else if (pos_q == dnsq_pkg::IP_PROTO && beat_byte != dnsq_pkg::IP_PROTO_UDP) begin
					drop = 1'b1;
				end else if (pos_q >= dnsq_pkg::IP_SRC_FIRST && pos_q <= dnsq_pkg::IP_SRC_LAST) begin
					src_n = {src_q[23:0], beat_byte};
				end
				if (drop) begin
					stay    = 1'b0;
					pos_n   = '0;
					phase_n = dnsq_pkg::PH_IDLE;
				end else if (pos_inc == ihl_n) begin
					stay    = 1'b0;
					pos_n   = '0;
					phase_n = dnsq_pkg::PH_UDP;
				end
			end
			dnsq_pkg::PH_UDP: begin
				if (pos_q >= dnsq_pkg::UDP_DPORT_HI && pos_q <= dnsq_pkg::UDP_LEN_LO) begin
					shift_n = shifted;
					sh      = shifted;
				end
				if (pos_q == dnsq_pkg::UDP_DPORT_LO && sh != dns_port) begin
					stay    = 1'b0;
					pos_n   = '0;
					phase_n = dnsq_pkg::PH_IDLE;
				end else if (pos_q == dnsq_pkg::UDP_LEN_LO) begin
					if (sh < dnsq_pkg::UDP_DNS_HDR) begin
						stay    = 1'b0;
						pos_n   = '0;
						phase_n = dnsq_pkg::PH_IDLE;
					end else begin
						rem_n = sh - dnsq_pkg::UDP_DNS_HDR;
					end
				end else if (pos_q == dnsq_pkg::UDP_LAST) begin
					stay    = 1'b0;
					pos_n   = '0;
					phase_n = dnsq_pkg::PH_DNS;
				end
			end
			dnsq_pkg::PH_DNS: begin
				if (pos_q == dnsq_pkg::DNS_FLAGS_HI && beat_byte[7]) begin
					stay    = 1'b0;
					pos_n   = '0;
					phase_n = dnsq_pkg::PH_IDLE;
				end else if (pos_q == dnsq_pkg::DNS_LAST) begin
					stay  = 1'b0;
					pos_n = '0;
					if (dns_empty) begin
						phase_n = dnsq_pkg::PH_IDLE;
					end else begin
						cnt_n   = '0;
						phase_n = dnsq_pkg::PH_CAP;
					end
				end
			end
			dnsq_pkg::PH_CAP: begin
				cnt_n = cnt_inc;
				rem_n = rem_dec;
				if (cap_last) begin
					stay    = 1'b0;
					pos_n   = '0;
					phase_n = dnsq_pkg::PH_IDLE;
				end
			end
			default: begin
			end
		endcase
		if (stay && phase_q != dnsq_pkg::PH_IDLE) pos_n = pos_inc;
		// Frame end restarts at the Ethernet header
		if (beat_end) begin
			phase_n = dnsq_pkg::PH_ETH;
			pos_n   = '0;
		end
	end

	// Result for the current beat
	always_comb begin
		res_valid          = 1'b0;
		res.source_address = src_q;
		res.packet_ident   = ident_q;
		res.query_byte     = '0;
		res.byte_index     = '0;
		res.has_byte       = 1'b0;
		res.last           = 1'b1;
		case (phase_q)
			dnsq_pkg::PH_DNS: begin
				res_valid = (pos_q == dnsq_pkg::DNS_LAST) && dns_empty &&
					!(pos_q == dnsq_pkg::DNS_FLAGS_HI && beat_byte[7]);
			end
			dnsq_pkg::PH_CAP: begin
				res_valid      = 1'b1;
				res.query_byte = beat_byte;
				res.byte_index = cnt_q[3:0];
				res.has_byte   = 1'b1;
				res.last       = cap_last;
			end
			default: begin
			end
		endcase
	end

	// Hold parse state; advance on each beat leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dnsq_pkg::PH_ETH;
			pos_q   <= '0;
			shift_q <= '0;
			ihl_q   <= '0;
			src_q   <= '0;
			ident_q <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			shift_q <= shift_n;
			ihl_q   <= ihl_n;
			src_q   <= src_n;
			ident_q <= ident_n;
			rem_q   <= rem_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/dnsq_out_reg.sv
// ----------------------------------------------------------------------------
// dnsq_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsq_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              res_valid,
	input  wire dnsq_pkg::result_t res,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output dnsq_pkg::result_t      out_res,
	output logic                   ready
);

	logic valid_q;
	dnsq_pkg::result_t res_q;

	// Free when empty or being taken this cycle
	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Load payload only when a new result arrives
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/dns_request_query_capture.sv
// ----------------------------------------------------------------------------
// dns_request_query_capture
// Captures the first question bytes of DNS requests from an Ethernet byte
// stream, tagged with the IPv4 source address and identification field.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one frame byte per beat, frame_end
//   high on the final byte of each frame. Output channel (out_valid /
//   out_stall): one result beat per captured question byte, or a single
//   beat with has_byte low for a request with an empty question; last marks
//   the final beat of a request's record.
//   A byte passes the input register and its result the output register.
//   Throughput: one byte per cycle while the receiver does not stall,
//   set by the input register, the single-pass header parser and the result
//   register. While the receiver stalls with a result held, the input
//   register fills and in_stall rises once it holds a beat; nothing is lost.
//   Reset clears both valid flags, restarts parsing at the Ethernet header
//   and loads dns_port with 53. Write dns_port (cfg_we / cfg_wdata) only
//   while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_request_query_capture #(
	parameter int CAPTURE_BYTES = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      source_address,
	output logic [15:0]      packet_ident,
	output logic [7:0]       query_byte,
	output logic [3:0]       byte_index,
	output logic             has_byte,
	output logic             last
);

	logic [15:0] dns_port_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        ready;
	logic        advance;
	logic        res_valid;
	dnsq_pkg::result_t res;
	dnsq_pkg::result_t out_res;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dns_port_q <= dnsq_pkg::DNS_PORT_RESET;
		end else if (cfg_we) begin
			dns_port_q <= cfg_wdata;
		end
	end

	// Input stage: move a beat on when the result register is free
	assign advance  = valid_s1 && ready;
	assign in_stall = valid_s1 && !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= frame_byte;
			end_s1  <= frame_end;
		end
	end

	dnsq_parser #(
		.CAPTURE_BYTES(CAPTURE_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.beat_byte (byte_s1),
		.beat_end  (end_s1),
		.dns_port  (dns_port_q),
		.res_valid (res_valid),
		.res       (res)
	);

	dnsq_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.ready     (ready)
	);

	assign source_address = out_res.source_address;
	assign packet_ident   = out_res.packet_ident;
	assign query_byte     = out_res.query_byte;
	assign byte_index     = out_res.byte_index;
	assign has_byte       = out_res.has_byte;
	assign last           = out_res.last;

`ifndef SYNTHESIS
	// Empty-question beat is a closed record with zeroed byte fields
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> last && query_byte == 8'd0 && byte_index == 4'd0)
		else $error("empty-question result malformed");

	// Input stalls only behind a held, stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while result register free");

	// No result appears without a beat in the input stage
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !valid_s1 |=> !out_valid)
		else $error("result produced without an input beat");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for dns_request_query_capture. Ethernet frames are built byte by
// byte from a frame description and pushed through the input channel. A
// parser model in the bench tracks every accepted byte and queues the result
// beats it should cause. A monitor checks each output beat against the
// oldest queued beat. Directed frames cover the header checks, the capture
// limit, empty questions, early frame ends and the port register extremes.
// A long receiver hold-off fills the block. Random well-formed and broken
// frames follow under a random port setting.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int CAPTURE_BYTES = 10;
	localparam int TAIL_CYCLES   = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 3000;

	// Receiver stall patterns
	localparam int RX_OPEN     = 0;
	localparam int RX_LIGHT    = 1;
	localparam int RX_HEAVY    = 2;
	localparam int RX_PERIODIC = 3;

	// Frame corruption choices for broken random frames
	localparam int BAD_ETHERTYPE = 0;
	localparam int BAD_IHL       = 1;
	localparam int BAD_PROTO     = 2;
	localparam int BAD_PORT      = 3;
	localparam int BAD_QR        = 4;
	localparam int BAD_UDP_LEN   = 5;

	// One frame to build: header fields plus question, trailer and cut length
	typedef struct packed {
		logic [15:0] ethertype;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [15:0] ident;
		logic [15:0] dport;
		logic [15:0] udp_len;
		logic [7:0]  flags_hi;
		logic [15:0] qlen;
		logic [15:0] cut;
		logic [15:0] trail;
	} frame_spec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  frame_byte = 8'd0;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] source_address;
	logic [15:0] packet_ident;
	logic [7:0]  query_byte;
	logic [3:0]  byte_index;
	logic        has_byte;
	logic        last;

	// Parser model state
	dnsq_pkg::phase_t prs_phase = dnsq_pkg::PH_ETH;
	logic [15:0] prs_pos = 16'd0;
	logic [15:0] prs_shift = 16'd0;
	logic [5:0]  prs_hdr_len = 6'd0;
	logic [31:0] prs_source = 32'd0;
	logic [15:0] prs_ident = 16'd0;
	logic [15:0] prs_left = 16'd0;
	logic [3:0]  prs_count = 4'd0;
	logic [15:0] prs_port = dnsq_pkg::DNS_PORT_RESET;

	dnsq_pkg::result_t awaited_beats[$];
	dnsq_pkg::result_t seen_want;
	int      failures = 0;
	int      bytes_sent = 0;
	int      beats_expected = 0;
	int      burst_left = 0;
	int      hold_trigger = 0;
	int      hold_seen = 0;
	int      hold_left = 0;
	int      rx_mode = RX_OPEN;
	int      rx_mode_left = 0;

	dns_request_query_capture #(
		.CAPTURE_BYTES(CAPTURE_BYTES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.frame_byte    (frame_byte),
		.frame_end     (frame_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.source_address(source_address),
		.packet_ident  (packet_ident),
		.query_byte    (query_byte),
		.byte_index    (byte_index),
		.has_byte      (has_byte),
		.last          (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void enter_phase(input dnsq_pkg::phase_t p);
		prs_phase = p;
		prs_pos = 16'd0;
	endfunction

	// Advance the parser model by one frame byte; return 1 when a beat results
	function automatic bit capture_step(input logic [7:0] b, input logic fe,
			output dnsq_pkg::result_t r);
		logic [15:0] pos;
		logic [3:0]  idx;
		bit          stay;
		bit          hit;
		bit          done;
		pos = prs_pos;
		stay = 1'b1;
		hit = 1'b0;
		r = '0;
		case (prs_phase)
		dnsq_pkg::PH_ETH: begin
			if (pos >= dnsq_pkg::ETH_TYPE_HI)
				prs_shift = {prs_shift[7:0], b};
			if (pos == dnsq_pkg::ETH_TYPE_LO) begin
				stay = 1'b0;
				enter_phase((prs_shift == dnsq_pkg::ETHERTYPE_IPV4) ?
					dnsq_pkg::PH_IP : dnsq_pkg::PH_IDLE);
			end
		end
		dnsq_pkg::PH_IP: begin
			if (pos == 16'd0 && b[3:0] < dnsq_pkg::IHL_MIN) begin
				stay = 1'b0;
				enter_phase(dnsq_pkg::PH_IDLE);
			end else if (pos == dnsq_pkg::IP_PROTO && b != dnsq_pkg::IP_PROTO_UDP) begin
				stay = 1'b0;
				enter_phase(dnsq_pkg::PH_IDLE);
			end else begin
				if (pos == 16'd0)
					prs_hdr_len = {b[3:0], 2'b00};
				else if (pos == dnsq_pkg::IP_IDENT_HI || pos == dnsq_pkg::IP_IDENT_LO)
					prs_ident = {prs_ident[7:0], b};
				else if (pos >= dnsq_pkg::IP_SRC_FIRST && pos <= dnsq_pkg::IP_SRC_LAST)
					prs_source = {prs_source[23:0], b};
				if (pos + 16'd1 == {10'd0, prs_hdr_len}) begin
					stay = 1'b0;
					enter_phase(dnsq_pkg::PH_UDP);
				end
			end
		end
		dnsq_pkg::PH_UDP: begin
			if (pos >= dnsq_pkg::UDP_DPORT_HI && pos <= dnsq_pkg::UDP_LEN_LO)
				prs_shift = {prs_shift[7:0], b};
			if (pos == dnsq_pkg::UDP_DPORT_LO && prs_shift != prs_port) begin
				stay = 1'b0;
				enter_phase(dnsq_pkg::PH_IDLE);
			end else if (pos == dnsq_pkg::UDP_LEN_LO) begin
				if (prs_shift < dnsq_pkg::UDP_DNS_HDR) begin
					stay = 1'b0;
					enter_phase(dnsq_pkg::PH_IDLE);
				end else begin
					prs_left = prs_shift - dnsq_pkg::UDP_DNS_HDR;
				end
			end else if (pos == dnsq_pkg::UDP_LAST) begin
				stay = 1'b0;
				enter_phase(dnsq_pkg::PH_DNS);
			end
		end
		dnsq_pkg::PH_DNS: begin
			if (pos == dnsq_pkg::DNS_FLAGS_HI && b[7]) begin
				stay = 1'b0;
				enter_phase(dnsq_pkg::PH_IDLE);
			end else if (pos == dnsq_pkg::DNS_LAST) begin
				stay = 1'b0;
				if (prs_left == 16'd0 || fe) begin
					// empty question: one marker beat with no byte
					r.source_address = prs_source;
					r.packet_ident = prs_ident;
					r.last = 1'b1;
					hit = 1'b1;
					enter_phase(dnsq_pkg::PH_IDLE);
				end else begin
					prs_count = 4'd0;
					enter_phase(dnsq_pkg::PH_CAP);
				end
			end
		end
		dnsq_pkg::PH_CAP: begin
			idx = prs_count;
			prs_count = idx + 4'd1;
			prs_left = prs_left - 16'd1;
			done = (prs_count >= CAPTURE_BYTES) || (prs_left == 16'd0) || fe;
			r.source_address = prs_source;
			r.packet_ident = prs_ident;
			r.query_byte = b;
			r.byte_index = idx;
			r.has_byte = 1'b1;
			r.last = done;
			hit = 1'b1;
			if (done) begin
				stay = 1'b0;
				enter_phase(dnsq_pkg::PH_IDLE);
			end
		end
		default: ;
		endcase
		if (stay && prs_phase != dnsq_pkg::PH_IDLE)
			prs_pos = pos + 16'd1;
		if (fe)
			enter_phase(dnsq_pkg::PH_ETH);
		return hit;
	endfunction

	// Offer one byte in bursts with random gaps; predict at acceptance
	task automatic send_beat(input logic [7:0] b, input logic fe);
		dnsq_pkg::result_t beat;
		int      gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		frame_byte <= b;
		frame_end <= fe;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		bytes_sent++;
		if (capture_step(b, fe, beat)) begin
			awaited_beats.push_back(beat);
			beats_expected++;
		end
	endtask

	// Stop offering, wait for every queued beat, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_beats.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_dns_port(input logic [15:0] port);
		cfg_we <= 1'b1;
		cfg_wdata <= port;
		@(posedge clk);
		cfg_we <= 1'b0;
		prs_port = port;
	endtask

	function automatic frame_spec_t request_spec(input int qlen);
		frame_spec_t s;
		s.ethertype = dnsq_pkg::ETHERTYPE_IPV4;
		s.ihl = dnsq_pkg::IHL_MIN;
		s.proto = dnsq_pkg::IP_PROTO_UDP;
		s.src = $urandom;
		s.ident = 16'($urandom_range(0, 65535));
		s.dport = prs_port;
		s.udp_len = dnsq_pkg::UDP_DNS_HDR + 16'(qlen);
		s.flags_hi = 8'($urandom_range(0, 127));
		s.qlen = 16'(qlen);
		s.cut = 16'd0;
		s.trail = 16'd0;
		return s;
	endfunction

	// Lay out MAC, IPv4, UDP and DNS headers, question and trailer, then send
	task automatic send_frame(input frame_spec_t s);
		logic [7:0] fb[$];
		int         hdr;
		int         n;
		int         i;
		fb = {};
		repeat (12) fb.push_back(8'($urandom_range(0, 255)));
		fb.push_back(s.ethertype[15:8]);
		fb.push_back(s.ethertype[7:0]);
		hdr = (s.ihl < dnsq_pkg::IHL_MIN) ? 20 : int'(s.ihl) * 4;
		for (i = 0; i < hdr; i++) begin
			case (i)
			0:  fb.push_back({4'($urandom_range(0, 15)), s.ihl});
			4:  fb.push_back(s.ident[15:8]);
			5:  fb.push_back(s.ident[7:0]);
			9:  fb.push_back(s.proto);
			12: fb.push_back(s.src[31:24]);
			13: fb.push_back(s.src[23:16]);
			14: fb.push_back(s.src[15:8]);
			15: fb.push_back(s.src[7:0]);
			default: fb.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		fb.push_back(8'($urandom_range(0, 255)));
		fb.push_back(8'($urandom_range(0, 255)));
		fb.push_back(s.dport[15:8]);
		fb.push_back(s.dport[7:0]);
		fb.push_back(s.udp_len[15:8]);
		fb.push_back(s.udp_len[7:0]);
		fb.push_back(8'($urandom_range(0, 255)));
		fb.push_back(8'($urandom_range(0, 255)));
		for (i = 0; i < 12; i++)
			fb.push_back((i == 2) ? s.flags_hi : 8'($urandom_range(0, 255)));
		repeat (int'(s.qlen) + int'(s.trail)) fb.push_back(8'($urandom_range(0, 255)));
		n = (s.cut > 0 && s.cut < fb.size()) ? int'(s.cut) : fb.size();
		for (i = 0; i < n; i++)
			send_beat(fb[i], i == n - 1);
	endtask

	// Random bytes with scattered frame ends, closed by a frame end
	task automatic send_noise(input int len);
		int i;
		for (i = 0; i < len; i++)
			send_beat(8'($urandom_range(0, 255)),
				(i == len - 1) || ($urandom_range(0, 15) == 0));
	endtask

	task automatic test_default_port_request();
		frame_spec_t s;
		// all-ones key, highest flags byte that is still a query
		s = request_spec(2);
		s.src = 32'hFFFF_FFFF;
		s.ident = 16'hFFFF;
		s.flags_hi = 8'h7F;
		send_frame(s);
		settle();
	endtask

	task automatic test_capture_limit();
		// longer question than the record holds: the rest is ignored
		send_frame(request_spec(14));
		settle();
	endtask

	task automatic test_empty_question();
		frame_spec_t s;
		send_frame(request_spec(0));
		// payload claims more, but the frame stops on the last DNS header byte
		s = request_spec(0);
		s.udp_len = 16'd40;
		s.cut = 16'd54;
		send_frame(s);
		settle();
	endtask

	task automatic test_early_frame_end();
		frame_spec_t s;
		s = request_spec(5);
		s.cut = 16'd50;
		send_frame(s);
		s = request_spec(3);
		s.udp_len = 16'hFFFF;
		send_frame(s);
		send_beat(8'hA5, 1'b1);
		s = request_spec(2);
		s.cut = 16'd14;
		send_frame(s);
		settle();
	endtask

	// Each broken frame ends two bytes after the field that rejects it
	task automatic test_rejected_frames();
		frame_spec_t s;
		s = request_spec(3);
		s.ethertype = 16'h86DD;
		s.cut = 16'd16;
		send_frame(s);
		s = request_spec(3);
		s.ihl = 4'd4;
		s.cut = 16'd17;
		send_frame(s);
		s = request_spec(3);
		s.proto = 8'd6;
		s.cut = 16'd26;
		send_frame(s);
		s = request_spec(3);
		s.dport = prs_port ^ 16'h0001;
		s.cut = 16'd40;
		send_frame(s);
		s = request_spec(3);
		s.flags_hi = 8'h80;
		s.cut = 16'd47;
		send_frame(s);
		s = request_spec(3);
		s.udp_len = 16'd19;
		s.cut = 16'd42;
		send_frame(s);
		settle();
	endtask

	task automatic test_port_extremes();
		frame_spec_t s;
		set_dns_port(16'd0);
		// longest IPv4 header as well
		s = request_spec(1);
		s.ihl = 4'd15;
		send_frame(s);
		settle();
		set_dns_port(16'hFFFF);
		send_frame(request_spec(1));
		settle();
		set_dns_port(dnsq_pkg::DNS_PORT_RESET);
	endtask

	task automatic test_backpressure();
		hold_trigger++;
		send_frame(request_spec(12));
		settle();
	endtask

	task automatic send_random_frame();
		frame_spec_t s;
		int          kind;
		kind = $urandom_range(0, 9);
		s = request_spec($urandom_range(0, 14));
		if ($urandom_range(0, 3) == 0)
			s.ihl = 4'($urandom_range(5, 15));
		if ($urandom_range(0, 4) == 0)
			s.trail = 16'($urandom_range(1, 6));
		case (kind)
		5: s.cut = 16'(34 + int'(s.ihl) * 4 + $urandom_range(0, s.qlen));
		6: s.cut = 16'($urandom_range(1, 60));
		7: begin
			case ($urandom_range(BAD_ETHERTYPE, BAD_UDP_LEN))
			BAD_ETHERTYPE: s.ethertype = 16'($urandom_range(0, 65535));
			BAD_IHL:       s.ihl = 4'($urandom_range(0, 4));
			BAD_PROTO:     s.proto = 8'($urandom_range(0, 255));
			BAD_PORT:      s.dport = 16'($urandom_range(0, 65535));
			BAD_QR:        s.flags_hi = s.flags_hi | 8'h80;
			default:       s.udp_len = 16'($urandom_range(0, 25));
			endcase
		end
		8: s.udp_len = 16'($urandom_range(0, 65535));
		default: ;
		endcase
		if (kind == 9)
			send_noise($urandom_range(1, 30));
		else
			send_frame(s);
	endtask

	task automatic test_random_traffic();
		int byte_goal;
		int beat_goal;
		settle();
		case ($urandom_range(0, 3))
		0: set_dns_port(dnsq_pkg::DNS_PORT_RESET);
		1: set_dns_port(16'd0);
		2: set_dns_port(16'hFFFF);
		default: set_dns_port(16'($urandom_range(0, 65535)));
		endcase
		byte_goal = bytes_sent + 60;
		beat_goal = beats_expected + 2;
		while (bytes_sent < byte_goal || beats_expected < beat_goal)
			send_random_frame();
		settle();
	endtask

	// Receiver: stall on a self-chosen pattern, or hold off on request
	always @(posedge clk) begin
		if (hold_seen != hold_trigger) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_CYCLES;
		end
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
			rx_mode_left = $urandom_range(20, 200);
		end
		rx_mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (rx_mode)
			RX_OPEN:  out_stall <= 1'b0;
			RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
			default:  out_stall <= ((rx_mode_left % 8) < 3);
			endcase
		end
	end

	// Check each accepted result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_beats.size() == 0) begin
				$error("result beat with none expected: source_address %h query_byte %h",
					source_address, query_byte);
				failures++;
			end else begin
				seen_want = awaited_beats.pop_front();
				if (source_address !== seen_want.source_address) begin
					$error("source_address: expected %h, got %h",
						seen_want.source_address, source_address);
					failures++;
				end
				if (packet_ident !== seen_want.packet_ident) begin
					$error("packet_ident: expected %h, got %h",
						seen_want.packet_ident, packet_ident);
					failures++;
				end
				if (query_byte !== seen_want.query_byte) begin
					$error("query_byte: expected %h, got %h", seen_want.query_byte, query_byte);
					failures++;
				end
				if (byte_index !== seen_want.byte_index) begin
					$error("byte_index: expected %0d, got %0d", seen_want.byte_index, byte_index);
					failures++;
				end
				if (has_byte !== seen_want.has_byte) begin
					$error("has_byte: expected %b, got %b", seen_want.has_byte, has_byte);
					failures++;
				end
				if (last !== seen_want.last) begin
					$error("last: expected %b, got %b", seen_want.last, last);
					failures++;
				end
			end
		end
	end

	// End the run when neither channel moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("dns_request_query_capture regression: fail");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_port_request();
		test_capture_limit();
		test_empty_question();
		test_early_frame_end();
		test_rejected_frames();
		test_port_extremes();
		test_backpressure();
		test_random_traffic();
		settle();
		if (failures == 0)
			$display("dns_request_query_capture regression: pass");
		else
			$display("dns_request_query_capture regression: fail");
		$finish;
	end

endmodule

### files.f
hw/rtl/dnsq_pkg.sv
hw/rtl/dnsq_parser.sv
hw/rtl/dnsq_out_reg.sv
hw/rtl/dns_request_query_capture.sv
tb/sv/tb_top.sv
